>>> hw/rtl/midi_voice_message_decoder_macros.svh
// assertion macros used by the decoder port checks
`ifndef MIDI_VOICE_MESSAGE_DECODER_MACROS_SVH
`define MIDI_VOICE_MESSAGE_DECODER_MACROS_SVH

// checked outside reset only
`define MVMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define MVMD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hw/rtl/mvmd_pkg.sv
// shared types, constants and helpers of the midi voice message decoder
`timescale 1ns / 1ps
`default_nettype none

package mvmd_pkg;

    localparam int MAP_DEPTH  = 128;
    localparam int MAP_AW     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int NOTE_W     = 7;
    localparam int VOICE_W    = 8;
    localparam int MODE_W     = 8;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // bend scaling: 400 * v - 200 * span, divided by span = 2^14 - 1
    localparam int BEND_DIV_BITS = 14;
    localparam int BEND_SPAN     = (1 << BEND_DIV_BITS) - 1;
    localparam int BEND_SCALE    = 400;
    localparam int BEND_OFFSET   = 200 * BEND_SPAN;
    localparam int BEND_PROD_W   = 23;
    localparam int BEND_MAG_W    = 22;
    localparam int BEND_W        = 9;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CONTROL  = 4'hB;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    localparam logic [NOTE_W-1:0] DAMPER_CONTROLLER = 7'h40;
    localparam logic [NOTE_W-1:0] DAMPER_THRESHOLD  = 7'd64;

    typedef enum logic [1:0] {
        CMD_PLAY    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_DAMPER  = 2'd2,
        CMD_BEND    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LISTEN_MASK   = 3'd0,
        REG_LOWEST_PITCH  = 3'd1,
        REG_HIGHEST_PITCH = 3'd2,
        REG_NOTE_MODE     = 3'd3,
        REG_MAP_ADDRESS   = 3'd4,
        REG_MAP_DATA      = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [MASK_W-1:0] listen_mask;
        logic [NOTE_W-1:0] lowest_pitch;
        logic [NOTE_W-1:0] highest_pitch;
        logic [MODE_W-1:0] note_mode;
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic [MAP_AW-1:0]  addr;
        logic [VOICE_W-1:0] data;
    } map_wr_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [VOICE_W-1:0]    voice;
        logic [NOTE_W-1:0]     pitch;
        logic [NOTE_W-1:0]     intensity;
        logic [MODE_W-1:0]     mode;
        logic                  damper_on;
        logic                  bend_neg;
        logic [BEND_MAG_W-1:0] bend_mag;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic note_in_range(input logic [NOTE_W-1:0] n,
                                           input logic [NOTE_W-1:0] lo,
                                           input logic [NOTE_W-1:0] hi);
        return (n >= lo) && (n <= hi) && ({1'b0, n} < (NOTE_W + 1)'(MAP_DEPTH));
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mvmd_regs.sv
// configuration registers and the pitch map write request
`timescale 1ns / 1ps
`default_nettype none

module mvmd_regs (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [mvmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [mvmd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output mvmd_pkg::cfg_t                     cfg,
    output mvmd_pkg::map_wr_t                  map_wr
);
    import mvmd_pkg::*;

    logic [MASK_W-1:0] listen_mask_reg;
    logic [NOTE_W-1:0] lowest_pitch_reg;
    logic [NOTE_W-1:0] highest_pitch_reg;
    logic [MODE_W-1:0] note_mode_reg;
    logic [NOTE_W-1:0] map_address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_mask_reg   <= '0;
            lowest_pitch_reg  <= '0;
            highest_pitch_reg <= '1;
            note_mode_reg     <= '0;
            map_address_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LISTEN_MASK:   listen_mask_reg   <= cfg_wdata[MASK_W-1:0];
                REG_LOWEST_PITCH:  lowest_pitch_reg  <= cfg_wdata[NOTE_W-1:0];
                REG_HIGHEST_PITCH: highest_pitch_reg <= cfg_wdata[NOTE_W-1:0];
                REG_NOTE_MODE:     note_mode_reg     <= cfg_wdata[MODE_W-1:0];
                REG_MAP_ADDRESS:   map_address_reg   <= cfg_wdata[NOTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.listen_mask   = listen_mask_reg;
    assign cfg.lowest_pitch  = lowest_pitch_reg;
    assign cfg.highest_pitch = highest_pitch_reg;
    assign cfg.note_mode     = note_mode_reg;

    // map data goes straight into the map, out-of-range addresses are dropped
    assign map_wr.en   = cfg_wr_en && (cfg_index == REG_MAP_DATA)
                         && note_in_range(map_address_reg, lowest_pitch_reg, highest_pitch_reg);
    assign map_wr.addr = map_address_reg[MAP_AW-1:0];
    assign map_wr.data = cfg_wdata[VOICE_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/mvmd_front.sv
// front end: message accept, classification, pitch map read and bend prescale
`timescale 1ns / 1ps
`default_nettype none

module mvmd_front (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [mvmd_pkg::S_DATA_W-1:0]     s_tdata,
    input  mvmd_pkg::cfg_t                    cfg,
    input  mvmd_pkg::map_wr_t                 map_wr,
    input  mvmd_pkg::qstat_t                  q_stat,
    output logic                              push,
    output mvmd_pkg::entry_t                  entry
);
    import mvmd_pkg::*;

    logic [7:0]        status;
    logic [NOTE_W-1:0] d1;
    logic [NOTE_W-1:0] d2;
    logic [3:0]        kind;
    logic [3:0]        chan;
    logic              accept;
    logic              load;

    logic                   emit;
    logic                   is_note;
    cmd_t                   cmd;
    logic [NOTE_W-1:0]      pitch;
    logic [NOTE_W-1:0]      intensity;
    logic [MODE_W-1:0]      mode;
    logic                   damper_on;
    logic                   bend_neg;
    logic [BEND_MAG_W-1:0]  bend_mag;
    logic [BEND_PROD_W-1:0] bend_prod;
    logic                   bend_below;

    logic                  stg_valid_reg;
    logic                  stg_valid_next;
    logic                  stg_is_note_reg;
    cmd_t                  stg_cmd_reg;
    logic [NOTE_W-1:0]     stg_pitch_reg;
    logic [NOTE_W-1:0]     stg_intensity_reg;
    logic [MODE_W-1:0]     stg_mode_reg;
    logic                  stg_damper_reg;
    logic                  stg_bend_neg_reg;
    logic [BEND_MAG_W-1:0] stg_bend_mag_reg;

    logic [VOICE_W-1:0]   map_mem_reg [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] map_valid_reg;
    logic [VOICE_W-1:0]   map_rd_data_reg;
    logic                 map_rd_valid_reg;

    assign status = s_tdata[7:0];
    assign d1     = s_tdata[14:8];
    assign d2     = s_tdata[21:15];
    assign kind   = status[7:4];
    assign chan   = status[3:0];

    assign push     = stg_valid_reg && !q_stat.full;
    assign s_tready = !stg_valid_reg || !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign load     = accept && emit;

    assign bend_prod  = BEND_PROD_W'({d2, d1}) * BEND_PROD_W'(BEND_SCALE);
    assign bend_below = bend_prod < BEND_PROD_W'(BEND_OFFSET);

    always_comb begin
        emit      = 1'b0;
        is_note   = 1'b0;
        cmd       = CMD_PLAY;
        pitch     = '0;
        intensity = '0;
        mode      = '0;
        damper_on = 1'b0;
        bend_neg  = 1'b0;
        bend_mag  = '0;
        unique case (kind) inside
            KIND_NOTE_ON, KIND_NOTE_OFF: begin
                emit    = cfg.listen_mask[chan]
                          && note_in_range(d1, cfg.lowest_pitch, cfg.highest_pitch);
                is_note = 1'b1;
                // note-on with zero velocity counts as a release
                if ((kind == KIND_NOTE_ON) && (d2 != '0)) begin
                    cmd       = CMD_PLAY;
                    pitch     = d1;
                    intensity = d2;
                    mode      = cfg.note_mode;
                end else begin
                    cmd = CMD_RELEASE;
                end
            end
            KIND_CONTROL: begin
                emit      = cfg.listen_mask[chan] && (d1 == DAMPER_CONTROLLER);
                cmd       = CMD_DAMPER;
                damper_on = d2 >= DAMPER_THRESHOLD;
            end
            KIND_BEND: begin
                emit     = cfg.listen_mask[chan];
                cmd      = CMD_BEND;
                bend_neg = bend_below;
                bend_mag = bend_below ? BEND_MAG_W'(BEND_PROD_W'(BEND_OFFSET) - bend_prod)
                                      : BEND_MAG_W'(bend_prod - BEND_PROD_W'(BEND_OFFSET));
            end
            default: ;
        endcase
    end

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (load) begin
            stg_valid_next = 1'b1;
        end else if (push) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stg_is_note_reg   <= is_note;
            stg_cmd_reg       <= cmd;
            stg_pitch_reg     <= pitch;
            stg_intensity_reg <= intensity;
            stg_mode_reg      <= mode;
            stg_damper_reg    <= damper_on;
            stg_bend_neg_reg  <= bend_neg;
            stg_bend_mag_reg  <= bend_mag;
        end
    end

    // pitch map: entries never written read as zero through the valid bits
    always_ff @(posedge aclk) begin
        if (map_wr.en) begin
            map_mem_reg[map_wr.addr] <= map_wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_valid_reg <= '0;
        end else if (map_wr.en) begin
            map_valid_reg[map_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && is_note) begin
            map_rd_data_reg  <= map_mem_reg[d1[MAP_AW-1:0]];
            map_rd_valid_reg <= map_valid_reg[d1[MAP_AW-1:0]];
        end
    end

    always_comb begin
        entry.cmd       = stg_cmd_reg;
        entry.voice     = (stg_is_note_reg && map_rd_valid_reg) ? map_rd_data_reg : '0;
        entry.pitch     = stg_pitch_reg;
        entry.intensity = stg_intensity_reg;
        entry.mode      = stg_mode_reg;
        entry.damper_on = stg_damper_reg;
        entry.bend_neg  = stg_bend_neg_reg;
        entry.bend_mag  = stg_bend_mag_reg;
    end

endmodule

`default_nettype wire

>>> hw/rtl/mvmd_queue.sv
// short request queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none

module mvmd_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  mvmd_pkg::entry_t      entry_in,
    input  wire                   pop,
    output mvmd_pkg::entry_t      entry_out,
    output mvmd_pkg::qstat_t      q_stat
);
    import mvmd_pkg::*;

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign entry_out    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mvmd_back.sv
// back end: bend division, result formatting and output register
`timescale 1ns / 1ps
`default_nettype none

module mvmd_back (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  mvmd_pkg::entry_t                  entry,
    input  mvmd_pkg::qstat_t                  q_stat,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [mvmd_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [mvmd_pkg::M_USER_W-1:0]     m_tuser
);
    import mvmd_pkg::*;

    logic [BEND_MAG_W:0]   bend_sum;
    logic [BEND_W-1:0]     bend_quot;
    logic [BEND_W-1:0]     bend_cents;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic [M_USER_W-1:0]   m_user_reg;

    // x / (2^k - 1) as (x + (x >> k) + 1) >> k, exact while the quotient stays below 2^k
    assign bend_sum   = (BEND_MAG_W + 1)'(entry.bend_mag)
                        + (BEND_MAG_W + 1)'(entry.bend_mag >> BEND_DIV_BITS)
                        + 1'b1;
    assign bend_quot  = BEND_W'(bend_sum >> BEND_DIV_BITS);
    assign bend_cents = entry.bend_neg ? (~bend_quot + 1'b1) : bend_quot;

    assign pop = !q_stat.empty && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_user_reg <= entry.cmd;
            m_data_reg <= {bend_cents, entry.damper_on, entry.mode,
                           entry.intensity, entry.pitch, entry.voice};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

>>> hw/rtl/midi_voice_message_decoder.sv
// top level of the midi channel voice message decoder
// Takes three-byte channel messages and turns each into at most one voice command:
// play, release, damper or a broadcast bend in cents. While the output does not
// stall it sustains one message per clock; the figure is set by the single pitch
// map read port, which is used once per note message. A result passes from its
// accepted message through the front stage with the map read, one queue slot,
// then the output register, and a two-entry queue between front and back lets
// the input keep flowing while a result waits. Messages that yield no command
// take no stage. The pitch map comes out of reset cleared through per-entry valid
// bits, so no clearing pass is needed and the block is ready right after reset.
// Users must write configuration only while no message is in flight; unenforced.
`timescale 1ns / 1ps
`default_nettype none

module midi_voice_message_decoder (
    input  wire                                aclk,
    input  wire                                aresetn,
    // tdata: status_byte[7:0], data_one[14:8], data_two[21:15], zero[23:22]
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [mvmd_pkg::S_DATA_W-1:0]      s_tdata,
    // tdata: voice[7:0], pitch[14:8], intensity[21:15], mode[29:22],
    //        damper_on[30], bend_cents[39:31]
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [mvmd_pkg::M_DATA_W-1:0]      m_tdata,
    // tuser: command[1:0]
    output logic [mvmd_pkg::M_USER_W-1:0]      m_tuser,
    input  wire                                cfg_wr_en,
    input  wire  [mvmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [mvmd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import mvmd_pkg::*;

    cfg_t    cfg;
    map_wr_t map_wr;
    qstat_t  q_stat;
    entry_t  front_entry;
    entry_t  head_entry;
    logic    push;
    logic    pop;

    mvmd_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .map_wr    (map_wr)
    );

    mvmd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .map_wr   (map_wr),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (front_entry)
    );

    mvmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .entry_in  (front_entry),
        .pop       (pop),
        .entry_out (head_entry),
        .q_stat    (q_stat)
    );

    mvmd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .entry    (head_entry),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> hw/rtl/mvmd_props.sv
// port-level checks of the decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "midi_voice_message_decoder_macros.svh"

module mvmd_props (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [mvmd_pkg::M_DATA_W-1:0]      m_tdata,
    input wire [mvmd_pkg::M_USER_W-1:0]      m_tuser
);
    import mvmd_pkg::*;

    `MVMD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `MVMD_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "result shown after reset")

    `MVMD_ASSERT(a_play_velocity, m_tvalid && (m_tuser == CMD_PLAY) |-> m_tdata[21:15] != 7'd0, "play with zero velocity")

    `MVMD_ASSERT(a_note_fields_clear, m_tvalid && (m_tuser != CMD_PLAY) |-> m_tdata[29:8] == 22'd0, "note fields set outside play")

    `MVMD_ASSERT(a_bend_range, m_tvalid && (m_tuser == CMD_BEND) |-> ($signed(m_tdata[39:31]) >= -9'sd200) && ($signed(m_tdata[39:31]) <= 9'sd200), "bend out of range")

endmodule

bind midi_voice_message_decoder mvmd_props u_props (.*);

`default_nettype wire

>>> sim/midi_voice_message_decoder_test.sv
// self-checking testbench for the midi channel voice message decoder
`timescale 1ns / 1ps

module midi_voice_message_decoder_test;
    import mvmd_pkg::*;

    localparam logic [3:0] KIND_KEY_PRESSURE = 4'hA;
    localparam logic [3:0] KIND_PROGRAM      = 4'hC;
    localparam logic [3:0] KIND_SYSTEM       = 4'hF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        cmd_t         cmd;
        logic [7:0]   voice;
        logic [6:0]   pitch;
        logic [6:0]   intensity;
        logic [7:0]   mode;
        logic         damper_on;
        logic [8:0]   bend_cents;
    } voice_command_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire  [M_DATA_W-1:0]   m_tdata;
    wire  [M_USER_W-1:0]   m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // mirror of the block's registers and pitch map
    logic [15:0] rx_mask   = 16'h0000;
    logic [6:0]  low_note  = 7'd0;
    logic [6:0]  high_note = 7'd127;
    logic [7:0]  play_mode = 8'd0;
    logic [6:0]  map_ptr   = 7'd0;
    logic [7:0]  map_value = 8'd0;
    logic [7:0]  voice_map [MAP_DEPTH];

    voice_command_t expected_commands[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  gaps_on = 1'b1;
    int  stall_request = 0;
    int  stall_left = 0;

    midi_voice_message_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit pitch_accepted(input logic [6:0] n);
        return (n >= low_note) && (n <= high_note) && (int'(n) < MAP_DEPTH);
    endfunction

    function automatic bit decode_message(input logic [7:0] status, input logic [6:0] d1,
                                          input logic [6:0] d2, output voice_command_t c);
        logic [3:0] kind;
        int         bend_value;
        int         cents;
        kind = status[7:4];
        c.cmd = CMD_PLAY;
        c.voice = '0;
        c.pitch = '0;
        c.intensity = '0;
        c.mode = '0;
        c.damper_on = 1'b0;
        c.bend_cents = '0;
        if (!rx_mask[status[3:0]])
            return 1'b0;
        if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
            if (!pitch_accepted(d1))
                return 1'b0;
            c.voice = voice_map[d1];
            // velocity zero on a note-on counts as a release
            if (kind == KIND_NOTE_ON && d2 != 0) begin
                c.pitch = d1;
                c.intensity = d2;
                c.mode = play_mode;
            end else begin
                c.cmd = CMD_RELEASE;
            end
            return 1'b1;
        end
        if (kind == KIND_CONTROL) begin
            if (d1 != DAMPER_CONTROLLER)
                return 1'b0;
            c.cmd = CMD_DAMPER;
            c.damper_on = (d2 >= DAMPER_THRESHOLD);
            return 1'b1;
        end
        if (kind == KIND_BEND) begin
            bend_value = int'(d1) + 128 * int'(d2);
            cents = (400 * bend_value - 200 * 16383) / 16383;
            c.cmd = CMD_BEND;
            c.bend_cents = cents[8:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        voice_command_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_commands.size() == 0) begin
                $error("unexpected command %0h, tdata %0h", m_tuser, m_tdata);
                errors++;
            end else begin
                want = expected_commands.pop_front();
                check_field("command", 16'(want.cmd), 16'(m_tuser[1:0]));
                check_field("voice", 16'(want.voice), 16'(m_tdata[7:0]));
                check_field("pitch", 16'(want.pitch), 16'(m_tdata[14:8]));
                check_field("intensity", 16'(want.intensity), 16'(m_tdata[21:15]));
                check_field("mode", 16'(want.mode), 16'(m_tdata[29:22]));
                check_field("damper_on", 16'(want.damper_on), 16'(m_tdata[30]));
                check_field("bend_cents", 16'(want.bend_cents), 16'(m_tdata[39:31]));
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge aclk) begin
        if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (gaps_on) begin
            m_tready <= ($urandom_range(99) >= 19);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // one request on the input side; returns on the falling edge after acceptance
    task automatic send_message(input logic [7:0] status, input logic [6:0] d1,
                                input logic [6:0] d2);
        voice_command_t c;
        while (gaps_on && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, d2, d1, status};
        do @(posedge aclk); while (!s_tready);
        if (decode_message(status, d1, d2, c))
            expected_commands.push_back(c);
        @(negedge aclk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_commands.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // only while idle; upper bits beyond the register width are sometimes set
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        logic [15:0] keep;
        logic [15:0] wdata;
        case (idx)
            REG_LISTEN_MASK: keep = 16'hFFFF;
            REG_NOTE_MODE, REG_MAP_DATA: keep = 16'h00FF;
            default: keep = 16'h007F;
        endcase
        wdata = value & keep;
        if ($urandom_range(3) == 0)
            wdata = wdata | (16'($urandom()) & ~keep);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wdata;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LISTEN_MASK:   rx_mask = wdata;
            REG_LOWEST_PITCH:  low_note = wdata[6:0];
            REG_HIGHEST_PITCH: high_note = wdata[6:0];
            REG_NOTE_MODE:     play_mode = wdata[7:0];
            REG_MAP_ADDRESS:   map_ptr = wdata[6:0];
            REG_MAP_DATA: begin
                map_value = wdata[7:0];
                if (pitch_accepted(map_ptr))
                    voice_map[map_ptr] = map_value;
            end
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic map_voice(input logic [6:0] note, input logic [7:0] voice);
        write_reg(REG_MAP_ADDRESS, 16'(note));
        write_reg(REG_MAP_DATA, 16'(voice));
    endtask

    task automatic set_window(input logic [15:0] mask, input logic [6:0] lo,
                              input logic [6:0] hi, input logic [7:0] mode);
        write_reg(REG_LISTEN_MASK, mask);
        write_reg(REG_LOWEST_PITCH, 16'(lo));
        write_reg(REG_HIGHEST_PITCH, 16'(hi));
        write_reg(REG_NOTE_MODE, 16'(mode));
    endtask

    // mostly well-formed messages on listened channels, the rest noise
    task automatic random_message(output logic [7:0] status, output logic [6:0] d1,
                                  output logic [6:0] d2);
        logic [3:0] chan;
        int         pick;
        pick = $urandom_range(99);
        chan = 4'($urandom());
        if (rx_mask != 0 && $urandom_range(99) < 85)
            while (!rx_mask[chan]) chan = 4'($urandom());
        d1 = 7'($urandom());
        d2 = 7'($urandom());
        if (pick < 55 && low_note <= high_note && $urandom_range(99) < 80)
            d1 = 7'($urandom_range(int'(high_note), int'(low_note)));
        if (pick < 30) begin
            status = {KIND_NOTE_ON, chan};
            if ($urandom_range(9) == 0) d2 = 7'd0;
        end else if (pick < 55) begin
            status = {KIND_NOTE_OFF, chan};
        end else if (pick < 70) begin
            status = {KIND_CONTROL, chan};
            if ($urandom_range(99) < 70) d1 = DAMPER_CONTROLLER;
        end else if (pick < 85) begin
            status = {KIND_BEND, chan};
        end else begin
            status = 8'($urandom());
        end
    endtask

    task automatic test_dropped_after_reset();
        // listen mask clears every channel after reset
        send_message({KIND_NOTE_ON, 4'h0}, 7'd60, 7'd100);
        send_message({KIND_BEND, 4'hF}, 7'd127, 7'd127);
        send_message({KIND_CONTROL, 4'h7}, DAMPER_CONTROLLER, 7'd127);
        drain_pipeline();
    endtask

    task automatic test_directed_messages();
        set_window(16'hFFFF, 7'd0, 7'd127, 8'hA5);
        map_voice(7'd0, 8'hFF);
        map_voice(7'd127, 8'h01);
        map_voice(7'd60, 8'h5A);
        send_message({KIND_NOTE_ON, 4'h0}, 7'd0, 7'd127);
        send_message({KIND_NOTE_ON, 4'hF}, 7'd127, 7'd1);
        send_message({KIND_NOTE_ON, 4'h5}, 7'd60, 7'd0);
        send_message({KIND_NOTE_OFF, 4'hA}, 7'd60, 7'd64);
        send_message({KIND_CONTROL, 4'h1}, DAMPER_CONTROLLER, 7'd63);
        send_message({KIND_CONTROL, 4'h2}, DAMPER_CONTROLLER, 7'd64);
        send_message({KIND_CONTROL, 4'h3}, DAMPER_CONTROLLER, 7'd0);
        send_message({KIND_CONTROL, 4'h4}, 7'h41, 7'd127);
        send_message({KIND_BEND, 4'h0}, 7'd0, 7'd0);
        send_message({KIND_BEND, 4'h1}, 7'd127, 7'd127);
        send_message({KIND_BEND, 4'h2}, 7'd0, 7'd64);
        send_message({KIND_BEND, 4'h3}, 7'd127, 7'd63);
        send_message({KIND_BEND, 4'h4}, 7'd1, 7'd0);
        send_message({KIND_KEY_PRESSURE, 4'h0}, 7'd60, 7'd100);
        send_message({KIND_PROGRAM, 4'h0}, 7'd5, 7'd0);
        send_message({KIND_SYSTEM, 4'h8}, 7'd0, 7'd0);
        drain_pipeline();
    endtask

    task automatic test_pitch_window();
        set_window(16'hFFFF, 7'd10, 7'd20, 8'h3C);
        map_voice(7'd15, 8'hC3);
        // outside the window: map write is dropped
        map_voice(7'd30, 8'h77);
        send_message({KIND_NOTE_OFF, 4'h3}, 7'd5, 7'd0);
        send_message({KIND_NOTE_ON, 4'h3}, 7'd25, 7'd90);
        send_message({KIND_NOTE_ON, 4'h3}, 7'd15, 7'd9);
        send_message({KIND_NOTE_OFF, 4'h3}, 7'd20, 7'd9);
        send_message({KIND_NOTE_ON, 4'h3}, 7'd10, 7'd127);
        drain_pipeline();
        // inverted window accepts no note and no map write
        write_reg(REG_LOWEST_PITCH, 16'd100);
        write_reg(REG_HIGHEST_PITCH, 16'd50);
        map_voice(7'd60, 8'h11);
        send_message({KIND_NOTE_ON, 4'h6}, 7'd60, 7'd40);
        send_message({KIND_NOTE_OFF, 4'h6}, 7'd60, 7'd40);
        send_message({KIND_BEND, 4'h6}, 7'd33, 7'd99);
        drain_pipeline();
        set_window(16'hFFFE, 7'd0, 7'd127, 8'h00);
        send_message({KIND_NOTE_ON, 4'h0}, 7'd30, 7'd50);
        send_message({KIND_NOTE_ON, 4'h1}, 7'd30, 7'd50);
        send_message({KIND_NOTE_ON, 4'h1}, 7'd60, 7'd50);
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [6:0] lo;
        logic [6:0] hi;
        int         count;
        for (int phase = 0; phase < 6; phase++) begin
            lo = 7'($urandom());
            hi = 7'($urandom_range(127, int'(lo)));
            count = 225;
            case (phase)
                0: set_window(16'hFFFF, 7'd0, 7'd127, 8'h00);
                1: set_window(16'($urandom()), lo, hi, 8'hFF);
                2: set_window(16'h0001, 7'd0, 7'd0, 8'($urandom()));
                3: set_window(16'h8000, 7'd127, 7'd127, 8'($urandom()));
                4: begin
                    set_window(16'hFFFF, 7'($urandom_range(127, 1)), 7'd0, 8'($urandom()));
                    count = 80;
                end
                default: set_window(16'($urandom()), lo, hi, 8'($urandom()));
            endcase
            if (phase == 0) begin
                for (int n = 0; n < MAP_DEPTH; n++)
                    map_voice(7'(n), 8'($urandom()));
            end else begin
                repeat (12) map_voice(7'($urandom()), 8'($urandom()));
            end
            // one phase runs with no stalls on either side
            gaps_on = (phase != 1);
            repeat (count) begin
                random_message(status, d1, d2);
                send_message(status, d1, d2);
            end
            drain_pipeline();
            gaps_on = 1'b1;
        end
    endtask

    task automatic test_output_backpressure();
        set_window(16'hFFFF, 7'd0, 7'd127, 8'h81);
        gaps_on = 1'b0;
        stall_request = 300;
        // every bend yields a command, so the queue fills and the input stalls
        repeat (50) send_message({KIND_BEND, 4'($urandom())}, 7'($urandom()), 7'($urandom()));
        gaps_on = 1'b1;
        drain_pipeline();
    endtask

    initial begin
        for (int n = 0; n < MAP_DEPTH; n++)
            voice_map[n] = 8'h00;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_dropped_after_reset();
        test_directed_messages();
        test_pitch_window();
        test_random_traffic();
        test_output_backpressure();
        drain_pipeline();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mvmd_pkg.sv
hw/rtl/mvmd_regs.sv
hw/rtl/mvmd_front.sv
hw/rtl/mvmd_queue.sv
hw/rtl/mvmd_back.sv
hw/rtl/midi_voice_message_decoder.sv
hw/rtl/mvmd_props.sv
sim/midi_voice_message_decoder_test.sv
